/* rtl/sca_pkg.sv */
// Shared types, outcome codes and the scan-code set 1 lookup for the
// scan-code to ASCII ring buffer. No dependencies.
package sca_pkg;

    localparam int SCAN_W = 8;
    localparam int CHAR_W = 7;

    // Result codes reported with every word.
    typedef enum logic [2:0] {
        OUT_STORED     = 3'd0,
        OUT_IGNORED    = 3'd1,
        OUT_DROPPED    = 3'd2,
        OUT_READ_OK    = 3'd3,
        OUT_READ_EMPTY = 3'd4
    } outcome_t;

    // Commands from the decode logic to the ring.
    typedef struct packed {
        logic              push;
        logic              pop;
        logic [CHAR_W-1:0] wdata;
    } ring_cmd_t;

    // Status from the ring back to the decode logic.
    typedef struct packed {
        logic empty;
        logic full;
    } ring_stat_t;

    // US scan-code set 1 make codes to ASCII. Zero means no mapping, which
    // also covers scan code zero, release codes and codes above 90.
    function automatic logic [CHAR_W-1:0] sca_keymap(input logic [SCAN_W-1:0] code);
        logic [CHAR_W-1:0] ch;
        case (code)
            8'd1:    ch = 7'h1B;
            8'd2:    ch = 7'h31;
            8'd3:    ch = 7'h32;
            8'd4:    ch = 7'h33;
            8'd5:    ch = 7'h34;
            8'd6:    ch = 7'h35;
            8'd7:    ch = 7'h36;
            8'd8:    ch = 7'h37;
            8'd9:    ch = 7'h38;
            8'd10:   ch = 7'h39;
            8'd11:   ch = 7'h30;
            8'd12:   ch = 7'h2D;
            8'd13:   ch = 7'h3D;
            8'd14:   ch = 7'h08;
            8'd15:   ch = 7'h09;
            8'd16:   ch = 7'h71;
            8'd17:   ch = 7'h77;
            8'd18:   ch = 7'h65;
            8'd19:   ch = 7'h72;
            8'd20:   ch = 7'h74;
            8'd21:   ch = 7'h79;
            8'd22:   ch = 7'h75;
            8'd23:   ch = 7'h69;
            8'd24:   ch = 7'h6F;
            8'd25:   ch = 7'h70;
            8'd26:   ch = 7'h5B;
            8'd27:   ch = 7'h5D;
            8'd28:   ch = 7'h0A;
            8'd30:   ch = 7'h61;
            8'd31:   ch = 7'h73;
            8'd32:   ch = 7'h64;
            8'd33:   ch = 7'h66;
            8'd34:   ch = 7'h67;
            8'd35:   ch = 7'h68;
            8'd36:   ch = 7'h6A;
            8'd37:   ch = 7'h6B;
            8'd38:   ch = 7'h6C;
            8'd39:   ch = 7'h3B;
            8'd40:   ch = 7'h27;
            8'd41:   ch = 7'h60;
            8'd43:   ch = 7'h5C;
            8'd44:   ch = 7'h7A;
            8'd45:   ch = 7'h78;
            8'd46:   ch = 7'h63;
            8'd47:   ch = 7'h76;
            8'd48:   ch = 7'h62;
            8'd49:   ch = 7'h6E;
            8'd50:   ch = 7'h6D;
            8'd51:   ch = 7'h2C;
            8'd52:   ch = 7'h2E;
            8'd53:   ch = 7'h2F;
            8'd55:   ch = 7'h2A;
            8'd57:   ch = 7'h20;
            8'd74:   ch = 7'h2D;
            8'd78:   ch = 7'h2B;
            default: ch = '0;
        endcase
        return ch;
    endfunction

endpackage

/* rtl/sca_in_if.sv */
// Input channel: valid/ready handshake carrying one keyboard event or read
// request per word. Depends on nothing.
interface sca_in_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic       data_ready;
    logic [7:0] scancode;

    modport source (output valid, output mode, output data_ready, output scancode,
                    input ready);
    modport sink   (input valid, input mode, input data_ready, input scancode,
                    output ready);
endinterface

/* rtl/sca_out_if.sv */
// Output channel: valid/ready handshake carrying one result word per request.
// Depends on sca_pkg for the outcome type.
interface sca_out_if
    import sca_pkg::*;
    ;
    logic       valid;
    logic       ready;
    logic [6:0] char_out;
    outcome_t   outcome;

    modport source (output valid, output char_out, output outcome, input ready);
    modport sink   (input valid, input char_out, input outcome, output ready);
endinterface

/* rtl/sca_ring.sv */
// Character ring buffer: memory, read and write pointers, full/empty status.
// Depends on sca_pkg for the command and status structs.
module sca_ring
    import sca_pkg::*;
#(
    parameter int RING_DEPTH = 256
) (
    input  logic              clk,
    input  logic              rst_n,
    input  ring_cmd_t         cmd,
    output ring_stat_t        stat,
    output logic [CHAR_W-1:0] rdata
);

    localparam int PTR_W = $clog2(RING_DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_DEPTH - 1);

    logic [CHAR_W-1:0] mem [RING_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CHAR_W-1:0] rdata_reg;

    // Pointer advance wraps from the last slot back to zero.
    always_comb
    begin
        wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
    end

    // One slot is always left free, so equal pointers mean empty.
    assign stat.empty = (wr_ptr_reg == rd_ptr_reg);
    assign stat.full  = (wr_ptr_next == rd_ptr_reg);
    assign rdata      = rdata_reg;

    // Pointer registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            if (cmd.push)
            begin
                wr_ptr_reg <= wr_ptr_next;
            end
            if (cmd.pop)
            begin
                rd_ptr_reg <= rd_ptr_next;
            end
        end
    end

    // Storage with a registered read port; a pop never hits the slot being
    // written because the ring is not empty.
    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            mem[wr_ptr_reg] <= cmd.wdata;
        end
        if (cmd.pop)
        begin
            rdata_reg <= mem[rd_ptr_reg];
        end
    end

endmodule

/* rtl/scancode_ascii_fifo_core.sv */
// Scan-code set 1 to ASCII translator feeding a character ring buffer.
// Depends on sca_pkg, sca_in_if, sca_out_if and sca_ring.
//
// Usage:
//   req carries one word per request: mode 0 is a keyboard event (data_ready,
//   scancode), mode 1 asks for the oldest stored character.
//   rsp returns exactly one word per request, in order: char_out and outcome
//   (stored, ignored, dropped because full, read ok, read empty).
//   The result is valid on rsp in the cycle after acceptance on req, and one
//   request is taken every cycle while the receiver is not stalling. Both come
//   from the single output register and the registered read port of the ring memory.
//   The ring has RING_DEPTH slots and holds at most RING_DEPTH-1 characters.
//   Reset empties the ring by clearing both pointers and drops any pending
//   result; the memory itself is not cleared and needs no clearing pass.
//   When the receiver stalls, the result word holds and req.ready goes low
//   until that word is taken; a word taken in the same cycle frees the slot.
module scancode_ascii_fifo_core
    import sca_pkg::*;
#(
    parameter int RING_DEPTH = 256
) (
    input  logic       clk,
    input  logic       rst_n,
    sca_in_if.sink     req,
    sca_out_if.source  rsp
);

    ring_cmd_t         ring_cmd;
    ring_stat_t        ring_stat;
    logic [CHAR_W-1:0] ring_rdata;
    logic [CHAR_W-1:0] ascii;
    logic              accept;
    outcome_t          outcome_next;
    outcome_t          outcome_reg;
    logic              out_valid_reg;

    // Take a new word whenever the result register is free or draining.
    assign req.ready = !out_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;

    // Translate the scan code; unmapped, zero and release codes give zero.
    assign ascii = sca_keymap(req.scancode);

    // Decide the outcome and drive the ring.
    always_comb
    begin
        ring_cmd.push  = 1'b0;
        ring_cmd.pop   = 1'b0;
        ring_cmd.wdata = ascii;
        outcome_next   = OUT_IGNORED;
        if (req.mode)
        begin
            if (ring_stat.empty)
            begin
                outcome_next = OUT_READ_EMPTY;
            end
            else
            begin
                outcome_next = OUT_READ_OK;
                ring_cmd.pop = accept;
            end
        end
        else if (req.data_ready && (ascii != '0))
        begin
            if (ring_stat.full)
            begin
                outcome_next = OUT_DROPPED;
            end
            else
            begin
                outcome_next  = OUT_STORED;
                ring_cmd.push = accept;
            end
        end
    end

    sca_ring #(
        .RING_DEPTH (RING_DEPTH)
    ) u_ring (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (ring_cmd),
        .stat  (ring_stat),
        .rdata (ring_rdata)
    );

    // Result valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            out_valid_reg <= req.valid;
        end
    end

    // Result outcome; the character itself sits in the ring's read register.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            outcome_reg <= outcome_next;
        end
    end

    assign rsp.valid    = out_valid_reg;
    assign rsp.outcome  = outcome_reg;
    assign rsp.char_out = (outcome_reg == OUT_READ_OK) ? ring_rdata : '0;

    // A pop is only issued on a ring that holds something.
    assert property (@(posedge clk) disable iff (!rst_n)
        ring_cmd.pop |-> !ring_stat.empty)
        else $error("pop issued on empty ring");

    // A push is only issued while a slot is free.
    assert property (@(posedge clk) disable iff (!rst_n)
        ring_cmd.push |-> !ring_stat.full)
        else $error("push issued on full ring");

    // The ring can never look full and empty at once.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(ring_stat.full && ring_stat.empty))
        else $error("ring reports full and empty together");

    // Every accepted word yields a valid result in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid_reg)
        else $error("accepted word produced no result");

endmodule

/* verif/scancode_ascii_fifo_monitor.sv */
// Watches both channels of the scan-code to ASCII ring buffer, predicts every
// result word and compares it with what the block returns.
// Depends on sca_pkg, sca_in_if and sca_out_if.
`timescale 1ns / 1ps

module scancode_ascii_fifo_monitor
    import sca_pkg::*;
#(
    parameter int RING_DEPTH = 256
) (
    input  logic clk,
    input  logic rst_n,
    sca_in_if    req,
    sca_out_if   rsp,
    output int   fail_count,
    output int   results_pending,
    output int   stored_count,
    output int   ignored_count,
    output int   dropped_count,
    output int   read_ok_count,
    output int   read_empty_count
);

    localparam int MAX_CODE = 90;

    typedef struct packed {
        logic [CHAR_W-1:0] char_out;
        outcome_t          outcome;
    } result_word_t;

    // US set 1 make codes to ASCII; zero marks a code with no character.
    logic [CHAR_W-1:0] ascii_by_code [0:MAX_CODE] = '{
        7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38,
        7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08,
        7'h09, 7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69, 7'h6F,
        7'h70, 7'h5B, 7'h5D, 7'h0A,
        7'h00, 7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C,
        7'h3B, 7'h27, 7'h60, 7'h00,
        7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E,
        7'h2F, 7'h00, 7'h2A, 7'h00, 7'h20,
        7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
        7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
        7'h2D, 7'h00, 7'h00, 7'h00, 7'h2B,
        7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
        7'h00, 7'h00
    };

    // Shadow copy of the ring and its pointers.
    logic [CHAR_W-1:0] char_ring [RING_DEPTH];
    int unsigned       wr_ptr;
    int unsigned       rd_ptr;
    result_word_t      expected_words [$];

    int n_fail;
    int n_stored;
    int n_ignored;
    int n_dropped;
    int n_read_ok;
    int n_read_empty;

    function automatic int unsigned ring_next(input int unsigned ptr);
        return (ptr + 1 == RING_DEPTH) ? 0 : ptr + 1;
    endfunction

    // Applies one request word to the shadow ring and returns the result word
    // the block owes for it.
    function automatic result_word_t apply_request(input logic       is_read,
                                                   input logic       has_data,
                                                   input logic [7:0] code);
        result_word_t      res;
        logic [CHAR_W-1:0] ascii;
        res.char_out = '0;
        res.outcome  = OUT_IGNORED;
        if (is_read)
        begin
            if (rd_ptr == wr_ptr)
            begin
                res.outcome = OUT_READ_EMPTY;
            end
            else
            begin
                res.char_out = char_ring[rd_ptr];
                res.outcome  = OUT_READ_OK;
                rd_ptr       = ring_next(rd_ptr);
            end
        end
        else if (has_data && code >= 1 && code <= MAX_CODE)
        begin
            ascii = ascii_by_code[code];
            if (ascii != '0)
            begin
                if (ring_next(wr_ptr) == rd_ptr)
                begin
                    res.outcome = OUT_DROPPED;
                end
                else
                begin
                    char_ring[wr_ptr] = ascii;
                    wr_ptr            = ring_next(wr_ptr);
                    res.outcome       = OUT_STORED;
                end
            end
        end
        return res;
    endfunction

    // Result words are checked before the request word of the same edge is
    // predicted, since a result always belongs to an older request.
    always @(posedge clk or negedge rst_n)
    begin
        result_word_t want;
        if (!rst_n)
        begin
            wr_ptr       = 0;
            rd_ptr       = 0;
            expected_words.delete();
            n_fail       = 0;
            n_stored     = 0;
            n_ignored    = 0;
            n_dropped    = 0;
            n_read_ok    = 0;
            n_read_empty = 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (expected_words.size() == 0)
                begin
                    $error("result word with none expected: char_out %0h, outcome %0d",
                           rsp.char_out, rsp.outcome);
                    n_fail++;
                end
                else
                begin
                    want = expected_words.pop_front();
                    if (rsp.char_out !== want.char_out)
                    begin
                        $error("char_out: expected %0h, actual %0h",
                               want.char_out, rsp.char_out);
                        n_fail++;
                    end
                    if (rsp.outcome !== want.outcome)
                    begin
                        $error("outcome: expected %0d, actual %0d",
                               want.outcome, rsp.outcome);
                        n_fail++;
                    end
                    case (want.outcome)
                        OUT_STORED:     n_stored++;
                        OUT_IGNORED:    n_ignored++;
                        OUT_DROPPED:    n_dropped++;
                        OUT_READ_OK:    n_read_ok++;
                        OUT_READ_EMPTY: n_read_empty++;
                        default:        ;
                    endcase
                end
            end
            if (req.valid && req.ready)
            begin
                expected_words.push_back(apply_request(req.mode, req.data_ready,
                                                       req.scancode));
            end
        end
        fail_count       <= n_fail;
        results_pending  <= expected_words.size();
        stored_count     <= n_stored;
        ignored_count    <= n_ignored;
        dropped_count    <= n_dropped;
        read_ok_count    <= n_read_ok;
        read_empty_count <= n_read_empty;
    end

endmodule

/* verif/scancode_ascii_fifo_core_test.sv */
// Top of the scan-code to ASCII ring buffer test: clock, reset, request and
// receiver stimulus, watchdog and verdict. Depends on sca_pkg, both channel
// interfaces, scancode_ascii_fifo_core and scancode_ascii_fifo_monitor.
`timescale 1ns / 1ps

module scancode_ascii_fifo_core_test
    import sca_pkg::*;
    ;

    localparam int RING_DEPTH  = 256;
    localparam int TOTAL_WORDS = 1500;
    localparam int QUIET_WORDS = 200;
    localparam int FILL_WORDS  = 300;
    localparam int DRAIN_WORDS = 270;
    localparam int HOLD_CYCLES = 400;
    localparam int STALL_LIMIT = 3000;

    logic clk;
    logic rst_n;

    sca_in_if  req ();
    sca_out_if rsp ();

    int fail_count;
    int results_pending;
    int stored_count;
    int ignored_count;
    int dropped_count;
    int read_ok_count;
    int read_empty_count;

    int words_sent;
    bit quiet;
    bit hold_request;

    scancode_ascii_fifo_core #(
        .RING_DEPTH(RING_DEPTH)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    scancode_ascii_fifo_monitor #(
        .RING_DEPTH(RING_DEPTH)
    ) u_monitor (
        .clk              (clk),
        .rst_n            (rst_n),
        .req              (req),
        .rsp              (rsp),
        .fail_count       (fail_count),
        .results_pending  (results_pending),
        .stored_count     (stored_count),
        .ignored_count    (ignored_count),
        .dropped_count    (dropped_count),
        .read_ok_count    (read_ok_count),
        .read_empty_count (read_empty_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Offers one request word, after an optional random gap, and holds it
    // until the block takes it.
    task automatic send_word(input logic is_read, input logic has_data,
                             input logic [7:0] code);
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            @(negedge clk);
            req.valid      <= 1'b0;
            req.mode       <= 1'($urandom_range(0, 1));
            req.data_ready <= 1'($urandom_range(0, 1));
            req.scancode   <= 8'($urandom);
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        @(negedge clk);
        req.valid      <= 1'b1;
        req.mode       <= is_read;
        req.data_ready <= has_data;
        req.scancode   <= code;
        do @(posedge clk); while (req.ready !== 1'b1);
        words_sent++;
    endtask

    task automatic key_event(input logic [7:0] code);
        send_word(1'b0, 1'b1, code);
    endtask

    // A read ignores data_ready and scancode, so those carry noise.
    task automatic read_char();
        send_word(1'b1, 1'($urandom_range(0, 1)), 8'($urandom));
    endtask

    // Mostly codes of the main key block, now and then the keypad signs.
    function automatic logic [7:0] pick_key();
        case ($urandom_range(0, 19))
            0:       return 8'd74;
            1:       return 8'd78;
            default: return 8'($urandom_range(1, 57));
        endcase
    endfunction

    // Sender stops offering and waits until every result word owed so far
    // has come back.
    task automatic wait_drained();
        @(negedge clk);
        req.valid <= 1'b0;
        wait (results_pending == 0);
    endtask

    // Receiver: random ready stretches and stalls, one long hold-off on
    // request, and no stalls once the run goes quiet.
    initial
    begin
        rsp.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                rsp.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
            end
            else if (quiet || $urandom_range(0, 2) != 0)
            begin
                rsp.ready <= 1'b1;
                repeat ($urandom_range(0, 19)) @(negedge clk);
            end
            else
            begin
                rsp.ready <= 1'b0;
                repeat ($urandom_range(0, 14)) @(negedge clk);
            end
        end
    end

    // Watchdog: ends the run when no word moves on either channel for too long.
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (req.valid && req.ready) || (rsp.valid && rsp.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $error("no word moved for %0d cycles", STALL_LIMIT);
        $display("FAIL");
        $finish;
    end

    // Request stimulus and verdict.
    initial
    begin
        int  kind;
        int  burst;
        bit  filled;
        rst_n          = 1'b0;
        req.valid      = 1'b0;
        req.mode       = 1'b0;
        req.data_ready = 1'b0;
        req.scancode   = 8'h00;
        quiet          = 1'b0;
        hold_request   = 1'b0;
        words_sent     = 0;
        filled         = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part: read on an empty ring with every field high, events
        // that must be ignored, special characters, then read them all back.
        send_word(1'b1, 1'b1, 8'hFF);
        send_word(1'b0, 1'b0, 8'h1E);
        key_event(8'h00);
        key_event(8'hFF);
        key_event(8'h9E);
        key_event(8'd91);
        key_event(8'd90);
        key_event(8'd29);
        key_event(8'd1);
        key_event(8'd14);
        key_event(8'd28);
        key_event(8'd43);
        key_event(8'd57);
        key_event(8'd74);
        key_event(8'd78);
        key_event(8'd55);
        repeat (9) read_char();

        // Random part: typing bursts, read bursts, noise and mixed traffic,
        // with one fill past the top of the ring under a long receiver stall.
        while (words_sent < TOTAL_WORDS)
        begin
            if (words_sent >= TOTAL_WORDS - QUIET_WORDS)
                quiet = 1'b1;
            if (!filled && words_sent >= 300)
            begin
                filled       = 1'b1;
                hold_request = 1'b1;
                repeat (FILL_WORDS) key_event(pick_key());
                wait_drained();
                repeat (DRAIN_WORDS) read_char();
                continue;
            end
            kind  = $urandom_range(0, 9);
            burst = $urandom_range(1, 30);
            case (kind)
                0, 1, 2, 3, 4:
                    repeat (burst) key_event(pick_key());
                5, 6, 7:
                    repeat (burst) read_char();
                8:
                    repeat ((burst + 2) / 3)
                        send_word(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                  8'($urandom));
                default:
                    repeat (burst)
                    begin
                        if ($urandom_range(0, 1) == 0)
                            key_event(pick_key());
                        else
                            read_char();
                    end
            endcase
        end

        @(negedge clk);
        req.valid <= 1'b0;
        wait (results_pending == 0);
        repeat (8) @(posedge clk);

        $display("Checked %0d request words: %0d stored, %0d ignored, %0d dropped full.",
                 words_sent, stored_count, ignored_count, dropped_count);
        $display("Reads: %0d returned a character, %0d found the ring empty.",
                 read_ok_count, read_empty_count);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
